>>> src/count_weighted_column_sampler_unit_assert.svh
// assertion macros for the count-weighted column sampler
// no dependencies; included by the modules that carry assertions
`ifndef COUNT_WEIGHTED_COLUMN_SAMPLER_UNIT_ASSERT_SVH
`define COUNT_WEIGHTED_COLUMN_SAMPLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// concurrent check, off while reset is asserted
`define CWCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check, also active during reset
`define CWCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CWCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CWCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> src/cwcs_pkg.sv
// shared constants and types of the count-weighted column sampler
// no dependencies
package cwcs_pkg;

  // parameter defaults
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int RAND_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 24;

  // field and register widths
  localparam int RAND_W  = 16;
  localparam int COL_W   = 6;
  localparam int CONST_W = 16;
  localparam int NCOL_W  = 7;

  // apb port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register reset values
  localparam logic [CONST_W-1:0] REG_CONST_RESET = 16'd1000;
  localparam logic [NCOL_W-1:0]  REG_NCOL_RESET  = 7'd64;

  // register index, taken from paddr bit 2
  localparam logic REG_CONST = 1'b0;
  localparam logic REG_NCOL  = 1'b1;

  // shared unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

>>> src/cwcs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cwcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/cwcs_alu.sv
// shared three-operand adder / subtractor with carry or borrow flag
// depends on cwcs_pkg
module cwcs_alu import cwcs_pkg::*; #(
  parameter int W = 26
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] c_i,
  input  alu_op_e      op_i,
  output logic [W-1:0] res_o,
  output logic         flag_o
);

  logic [W+1:0] ext;

  // add: flag marks a carry out of W bits; sub: flag marks a negative result
  always_comb begin
    unique case (op_i)
      ALU_ADD: begin
        ext    = (W+2)'(a_i) + (W+2)'(b_i) + (W+2)'(c_i);
        flag_o = |ext[W+1:W];
      end
      ALU_SUB: begin
        ext    = (W+2)'(a_i) - (W+2)'(b_i) - (W+2)'(c_i);
        flag_o = ext[W+1];
      end
      default: begin
        ext    = '0;
        flag_o = 1'b0;
      end
    endcase
  end

  assign res_o = ext[W-1:0];

endmodule

>>> src/count_weighted_column_sampler_unit.sv
// requests: one at a time; the scan visits 1..n columns, n being the effective column count
// a new request is taken only after the result has moved to the result register; the shared adder handles the
//   16-step share division, the RAND_BITS-step threshold multiply and one column per cycle
// reset: asynchronous, active low; afterwards a pass over all MAX_COLUMNS entries clears the count
//   memory, during which no request is taken (register writes still are)
// top level of the count-weighted column sampler
// depends on cwcs_pkg, cwcs_alu, cwcs_ram and the assertion macro header
`include "count_weighted_column_sampler_unit_assert.svh"

module count_weighted_column_sampler_unit import cwcs_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int RAND_BITS   = RAND_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] random_value
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [5:0] column_index, [7:6] zero
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IW  = $clog2(MAX_COLUMNS);
  localparam int NB  = $clog2(MAX_COLUMNS + 1);
  localparam int NW  = (NB > NCOL_W) ? NB : NCOL_W;
  localparam int DW  = ((COUNT_BITS > CONST_W) ? COUNT_BITS : CONST_W) + 1;
  localparam int AW  = DW + 1;
  localparam int SW  = (RAND_BITS > CONST_W) ? RAND_BITS : CONST_W;
  localparam int STW = $clog2(SW);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_DIV,
    ST_DENOM,
    ST_MUL,
    ST_PRIME,
    ST_SCAN,
    ST_FETCH,
    ST_WRITE,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [RAND_BITS-1:0] r_q;
  logic [NB-1:0]        n_q;
  logic [COUNT_BITS-1:0] cc_q;
  logic [CONST_W-1:0]   c_sh_q;
  logic [NB-1:0]        rem_q;
  logic [CONST_W-1:0]   share_q;
  logic [DW-1:0]        denom_q;
  logic [DW-1:0]        hi_q;
  logic [STW-1:0]       step_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        pick_q;
  logic                 m_valid_q;
  logic [COL_W-1:0]     m_col_q;

  logic [CONST_W-1:0]   reg_const_q;
  logic [NCOL_W-1:0]    reg_ncol_q;

  // register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_const_q <= REG_CONST_RESET;
      reg_ncol_q  <= REG_NCOL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CONST: reg_const_q <= pwdata[CONST_W-1:0];
        REG_NCOL:  reg_ncol_q  <= pwdata[NCOL_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CONST: prdata = APB_DATA_W'(reg_const_q);
      REG_NCOL:  prdata = APB_DATA_W'(reg_ncol_q);
      default:   prdata = '0;
    endcase
  end

  // effective column count: zero acts as one, capped at the memory depth
  logic [NW-1:0] ncol_ext;
  logic [NB-1:0] n_eff;
  always_comb begin
    ncol_ext = NW'(reg_ncol_q);
    if (ncol_ext == '0) begin
      n_eff = NB'(1);
    end else if (ncol_ext > NW'(MAX_COLUMNS)) begin
      n_eff = NB'(MAX_COLUMNS);
    end else begin
      n_eff = ncol_ext[NB-1:0];
    end
  end

  // random fraction, low RAND_BITS bits
  logic [31:0] rnd_ext;
  assign rnd_ext = 32'(s_axis_tdata);

  // count memory
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  cwcs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared adder
  logic [AW-1:0] alu_a, alu_b, alu_c, alu_res;
  alu_op_e       alu_op;
  logic          alu_flag;

  cwcs_alu #(
    .W (AW)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .c_i    (alu_c),
    .op_i   (alu_op),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  // division trial value: remainder with the next dividend bit shifted in
  logic [NB:0] trial;
  assign trial = {rem_q, c_sh_q[CONST_W-1]};

  // operand selection per step
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    alu_op = ALU_ADD;
    unique case (state_q)
      ST_INC: begin
        alu_a = AW'(cc_q);
        alu_b = AW'(1'b1);
      end
      ST_DIV: begin
        alu_a  = AW'(trial);
        alu_b  = AW'(n_q);
        alu_op = ALU_SUB;
      end
      ST_DENOM: begin
        alu_a = AW'(cc_q);
        alu_b = AW'(reg_const_q);
      end
      ST_MUL: begin
        alu_a = AW'(hi_q);
        alu_b = r_q[0] ? AW'(denom_q) : '0;
      end
      ST_SCAN: begin
        alu_a  = AW'(hi_q);
        alu_b  = AW'(ram_rdata);
        alu_c  = AW'(share_q);
        alu_op = ALU_SUB;
      end
      ST_WRITE: begin
        alu_a = AW'(ram_rdata);
        alu_b = AW'(1'b1);
      end
      default: ;
    endcase
  end

  // memory addressing
  logic scan_last;
  assign scan_last = (NB'(idx_q) == n_q - NB'(1));

  always_comb begin
    unique case (state_q)
      ST_SCAN:  ram_raddr = idx_q + IW'(1);
      ST_FETCH: ram_raddr = pick_q;
      default:  ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick_q;
    ram_wdata = alu_res[COUNT_BITS-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
      end
      ST_WRITE: ram_we = !alu_res[COUNT_BITS];
      default: ;
    endcase
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      r_q       <= '0;
      n_q       <= NB'(1);
      cc_q      <= '0;
      c_sh_q    <= '0;
      rem_q     <= '0;
      share_q   <= '0;
      denom_q   <= '0;
      hi_q      <= '0;
      step_q    <= '0;
      idx_q     <= '0;
      pick_q    <= '0;
      m_valid_q <= 1'b0;
      m_col_q   <= '0;
    end else begin
      // result register: loaded from the output step, emptied on a handshake
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + IW'(1);
          if (idx_q == IW'(MAX_COLUMNS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            r_q     <= rnd_ext[RAND_BITS-1:0];
            n_q     <= n_eff;
            state_q <= ST_INC;
          end
        end
        // saturating call count
        ST_INC: begin
          if (!alu_res[COUNT_BITS]) begin
            cc_q <= alu_res[COUNT_BITS-1:0];
          end
          c_sh_q  <= reg_const_q;
          rem_q   <= '0;
          share_q <= '0;
          step_q  <= STW'(CONST_W - 1);
          state_q <= ST_DIV;
        end
        // restoring division, one quotient bit per cycle
        ST_DIV: begin
          rem_q   <= alu_flag ? trial[NB-1:0] : alu_res[NB-1:0];
          share_q <= {share_q[CONST_W-2:0], !alu_flag};
          c_sh_q  <= c_sh_q << 1;
          step_q  <= step_q - STW'(1);
          if (step_q == '0) begin
            state_q <= ST_DENOM;
          end
        end
        ST_DENOM: begin
          denom_q <= alu_res[DW-1:0];
          hi_q    <= '0;
          step_q  <= STW'(RAND_BITS - 1);
          state_q <= ST_MUL;
        end
        // shift-add multiply keeping only the bits above RAND_BITS
        ST_MUL: begin
          hi_q    <= alu_res[AW-1:1];
          r_q     <= r_q >> 1;
          step_q  <= step_q - STW'(1);
          if (step_q == '0) begin
            state_q <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          idx_q   <= '0;
          state_q <= ST_SCAN;
        end
        // residual threshold minus running sum; pick where it turns negative
        ST_SCAN: begin
          if (alu_flag) begin
            pick_q  <= idx_q;
            state_q <= ST_FETCH;
          end else if (scan_last) begin
            pick_q  <= '0;
            state_q <= ST_FETCH;
          end else begin
            hi_q  <= alu_res[DW-1:0];
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_FETCH: state_q <= ST_WRITE;
        ST_WRITE: state_q <= ST_OUT;
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_col_q   <= COL_W'(pick_q);
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 8'(m_col_q);

  // checks
  `CWCS_ASSERT_ALWAYS(a_clear_blocks_req, clk_i, (state_q == ST_CLEAR) |-> !s_axis_tready, "request taken during clearing pass")
  `CWCS_ASSERT(a_ncol_range, clk_i, rst_ni, (state_q != ST_IDLE && state_q != ST_CLEAR) |-> (n_q != '0 && n_q <= NB'(MAX_COLUMNS)), "effective column count out of range")
  `CWCS_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q == ST_SCAN) |-> (NB'(idx_q) < n_q), "scan ran past the last column")
  `CWCS_ASSERT(a_thresh_below_denom, clk_i, rst_ni, (state_q == ST_PRIME) |-> (hi_q < denom_q), "threshold not below denominator")
  `CWCS_ASSERT(a_result_from_out, clk_i, rst_ni, $rose(m_valid_q) |-> ($past(state_q) == ST_OUT), "result raised outside output step")

endmodule
